// ===== src/sfd_pkg.sv =====
// ----------------------------------------------------------------------------
// sfd_pkg
// Shared types and constants of the stereo feedback delay: register indexes,
// field widths, sequencer states and the control bundle to the channel paths.
// ----------------------------------------------------------------------------
package sfd_pkg;

  localparam int SAMPLE_BITS_DEF   = 24;
  localparam int HISTORY_DEPTH_DEF = 131072;

  localparam int GAIN_BITS      = 16;
  localparam int DELAY_BITS     = 17;
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = DELAY_BITS;

  // Q1.15 gains: half an LSB of the scaled product, and the fraction width
  localparam int Q_FRAC     = 15;
  localparam int ROUND_HALF = 16384;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_WET_GAIN      = 2'd0,
    CFG_FEEDBACK_GAIN = 2'd1,
    CFG_LEFT_DELAY    = 2'd2,
    CFG_RIGHT_DELAY   = 2'd3
  } sfd_cfg_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WET,
    S_OUT,
    S_FB,
    S_STORE
  } sfd_state_e;

  typedef struct packed {
    logic accept;    // latch the input beat, read the history
    logic wet_mul;   // wet gain times delayed sample
    logic out_load;  // load the result register
    logic fb_mul;    // feedback gain times result
    logic store;     // write the history entry
  } sfd_ctrl_t;

  // Number of restoring steps that reduce a delay modulo the depth: the count
  // of shifts k for which depth << k still fits the delay range.
  function automatic int red_steps(input longint depth);
    int n;
    n = 0;
    for (int k = 0; k < DELAY_BITS; k++) begin
      if ((depth << k) <= ((longint'(1) << DELAY_BITS) - 1)) begin
        n = k + 1;
      end
    end
    return n;
  endfunction

endpackage

// ===== src/sfd_delay_mod.sv =====
// ----------------------------------------------------------------------------
// sfd_delay_mod
// Holds one channel's delay register and reduces it modulo the history depth
// with a restoring subtract, one shifted depth per cycle after each write.
// ----------------------------------------------------------------------------
module sfd_delay_mod #(
  parameter int HISTORY_DEPTH = sfd_pkg::HISTORY_DEPTH_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 load_i,
  input  logic [sfd_pkg::DELAY_BITS-1:0]       value_i,
  output logic [$clog2(HISTORY_DEPTH)-1:0]     dmod_o,
  output logic                                 busy_o
);

  localparam int AddrBits = $clog2(HISTORY_DEPTH);
  localparam int DlyBits  = sfd_pkg::DELAY_BITS;
  localparam int Steps    = sfd_pkg::red_steps(longint'(HISTORY_DEPTH));

  logic [DlyBits-1:0] rem_q;

  assign dmod_o = AddrBits'(rem_q);

  if (Steps > 0) begin : g_reduce
    localparam logic [DlyBits-1:0] TopDiv  =
      DlyBits'(longint'(HISTORY_DEPTH) << (Steps - 1));
    localparam logic [DlyBits-1:0] DepthDv = DlyBits'(HISTORY_DEPTH);

    logic [DlyBits-1:0] div_q;
    logic               busy_q;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        rem_q  <= DlyBits'(1);
        div_q  <= DepthDv;
        busy_q <= 1'b0;
      end else if (load_i) begin
        rem_q  <= value_i;
        div_q  <= TopDiv;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        if (rem_q >= div_q) begin
          rem_q <= rem_q - div_q;
        end
        div_q <= div_q >> 1;
        // last step uses the depth itself
        if (div_q == DepthDv) begin
          busy_q <= 1'b0;
        end
      end
    end

    assign busy_o = busy_q;
  end else begin : g_direct
    // every delay value is already below the depth
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        rem_q <= DlyBits'(1);
      end else if (load_i) begin
        rem_q <= value_i;
      end
    end

    assign busy_o = 1'b0;
  end

endmodule

// ===== src/sfd_history.sv =====
// ----------------------------------------------------------------------------
// sfd_history
// Sample history of one channel: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module sfd_history #(
  parameter int DEPTH = sfd_pkg::HISTORY_DEPTH_DEF,
  parameter int WIDTH = sfd_pkg::SAMPLE_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/sfd_channel.sv =====
// ----------------------------------------------------------------------------
// sfd_channel
// One channel of the echo: delayed-sample address, history memory, shared
// gain multiplier, rounding and saturation, and the result register.
// ----------------------------------------------------------------------------
module sfd_channel #(
  parameter int HISTORY_DEPTH = sfd_pkg::HISTORY_DEPTH_DEF,
  parameter int SAMPLE_BITS   = sfd_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                   clk_i,
  input  sfd_pkg::sfd_ctrl_t                     ctrl_i,
  input  logic [$clog2(HISTORY_DEPTH)-1:0]       wp_i,
  input  logic                                   wrapped_i,
  input  logic [$clog2(HISTORY_DEPTH)-1:0]       dmod_i,
  input  logic [sfd_pkg::GAIN_BITS-1:0]          wet_gain_i,
  input  logic [sfd_pkg::GAIN_BITS-1:0]          fb_gain_i,
  input  logic signed [SAMPLE_BITS-1:0]          sample_i,
  output logic signed [SAMPLE_BITS-1:0]          out_o
);

  localparam int AddrBits = $clog2(HISTORY_DEPTH);
  localparam int ProdBits = SAMPLE_BITS + sfd_pkg::GAIN_BITS + 1;
  localparam int ScBits   = ProdBits - sfd_pkg::Q_FRAC;
  localparam int SumBits  = SAMPLE_BITS + 3;
  localparam logic signed [SumBits-1:0] SatHi =
    SumBits'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
  localparam logic signed [SumBits-1:0] SatLo = ~SatHi;

  logic [AddrBits:0]              wrap_sum;
  logic [AddrBits-1:0]            raddr;
  logic                           hit;
  logic                           hit_q;
  logic signed [SAMPLE_BITS-1:0]  in_q;
  logic signed [SAMPLE_BITS-1:0]  out_q;
  logic [SAMPLE_BITS-1:0]         rdata;
  logic signed [SAMPLE_BITS-1:0]  delayed;
  logic signed [SAMPLE_BITS-1:0]  mul_opnd;
  logic [sfd_pkg::GAIN_BITS-1:0]  mul_gain;
  logic signed [ProdBits-1:0]     prod_d;
  logic signed [ProdBits-1:0]     prod_q;
  logic signed [ProdBits-1:0]     rnd_sum;
  logic signed [ScBits-1:0]       scaled;
  logic signed [SAMPLE_BITS-1:0]  sat_res;

  // read position wraps below zero by adding the depth
  assign wrap_sum = {1'b0, wp_i} + (AddrBits + 1)'(HISTORY_DEPTH) - {1'b0, dmod_i};
  assign raddr    = (wp_i >= dmod_i) ? (wp_i - dmod_i) : wrap_sum[AddrBits-1:0];
  // entries are written in address order: below wp, or anywhere once wrapped
  assign hit      = wrapped_i || (raddr < wp_i);

  sfd_history #(
    .DEPTH (HISTORY_DEPTH),
    .WIDTH (SAMPLE_BITS)
  ) u_history (
    .clk_i   (clk_i),
    .we_i    (ctrl_i.store),
    .waddr_i (wp_i),
    .wdata_i (sat_res),
    .re_i    (ctrl_i.accept),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign delayed  = hit_q ? $signed(rdata) : '0;
  assign mul_gain = ctrl_i.fb_mul ? fb_gain_i : wet_gain_i;
  assign mul_opnd = ctrl_i.fb_mul ? out_q : delayed;
  assign prod_d   = ProdBits'($signed({1'b0, mul_gain})) * ProdBits'(mul_opnd);

  // round half up: floor((p + half) / 2^15)
  assign rnd_sum = prod_q + ProdBits'(sfd_pkg::ROUND_HALF);
  assign scaled  = rnd_sum[ProdBits-1:sfd_pkg::Q_FRAC];

  always_comb begin
    logic signed [SumBits-1:0] sum;
    sum = SumBits'(in_q) + SumBits'(scaled);
    if (sum > SatHi) begin
      sat_res = SatHi[SAMPLE_BITS-1:0];
    end else if (sum < SatLo) begin
      sat_res = SatLo[SAMPLE_BITS-1:0];
    end else begin
      sat_res = sum[SAMPLE_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.accept) begin
      in_q  <= sample_i;
      hit_q <= hit;
    end
    if (ctrl_i.wet_mul || ctrl_i.fb_mul) begin
      prod_q <= prod_d;
    end
    if (ctrl_i.out_load) begin
      out_q <= sat_res;
    end
  end

  assign out_o = out_q;

endmodule

// ===== src/stereo_feedback_delay_top.sv =====
// ----------------------------------------------------------------------------
// stereo_feedback_delay_top
// Stereo feedback echo on signed samples. A frame is taken when the block is
// idle and passes through history read, wet multiply, result, feedback
// multiply and history write before the next beat is taken, one after the
// other on each channel's single history memory and shared multiplier. The
// result beat follows the input through the wet multiply and result steps and
// waits in an output register; the next input beat is still taken while it
// waits, but that frame holds at its result step until the old one is taken.
// After a write to a delay register the input stalls while the delay is
// reduced modulo the depth, but not when the depth is above the delay range.
// No clearing pass follows reset: entries not yet written since reset read
// as zero.
// ----------------------------------------------------------------------------
module stereo_feedback_delay_top #(
  parameter int HISTORY_DEPTH = sfd_pkg::HISTORY_DEPTH_DEF,
  parameter int SAMPLE_BITS   = sfd_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [sfd_pkg::CFG_INDEX_BITS-1:0]    cfg_index_i,
  input  logic [sfd_pkg::CFG_DATA_BITS-1:0]     cfg_data_i,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic signed [SAMPLE_BITS-1:0]         left_in_i,
  input  logic signed [SAMPLE_BITS-1:0]         right_in_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [SAMPLE_BITS-1:0]         left_out_o,
  output logic signed [SAMPLE_BITS-1:0]         right_out_o
);

  localparam int AddrBits = $clog2(HISTORY_DEPTH);
  localparam int GainBits = sfd_pkg::GAIN_BITS;

  sfd_pkg::sfd_state_e state_q, state_d;
  sfd_pkg::sfd_ctrl_t  ctrl;

  logic [GainBits-1:0] wet_gain_q;
  logic [GainBits-1:0] fb_gain_q;
  logic [AddrBits-1:0] wp_q;
  logic                wrapped_q;
  logic                out_valid_q;
  logic                accept;
  logic                out_full;
  logic [AddrBits-1:0] left_dmod;
  logic [AddrBits-1:0] right_dmod;
  logic                left_busy;
  logic                right_busy;
  logic                dly_busy;
  logic                left_load;
  logic                right_load;

  // configuration
  assign left_load  = cfg_we_i && (cfg_index_i == sfd_pkg::CFG_LEFT_DELAY);
  assign right_load = cfg_we_i && (cfg_index_i == sfd_pkg::CFG_RIGHT_DELAY);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wet_gain_q <= '0;
      fb_gain_q  <= '0;
    end else if (cfg_we_i) begin
      if (cfg_index_i == sfd_pkg::CFG_WET_GAIN) begin
        wet_gain_q <= cfg_data_i[GainBits-1:0];
      end
      if (cfg_index_i == sfd_pkg::CFG_FEEDBACK_GAIN) begin
        fb_gain_q <= cfg_data_i[GainBits-1:0];
      end
    end
  end

  sfd_delay_mod #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_left_dly (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (left_load),
    .value_i (cfg_data_i),
    .dmod_o  (left_dmod),
    .busy_o  (left_busy)
  );

  sfd_delay_mod #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_right_dly (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (right_load),
    .value_i (cfg_data_i),
    .dmod_o  (right_dmod),
    .busy_o  (right_busy)
  );

  assign dly_busy = left_busy || right_busy;

  // sequencer
  assign in_stall_o = (state_q != sfd_pkg::S_IDLE) || dly_busy;
  assign accept     = in_valid_i && !in_stall_o;
  assign out_full   = out_valid_q && out_stall_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sfd_pkg::S_IDLE:  if (accept) state_d = sfd_pkg::S_WET;
      sfd_pkg::S_WET:   state_d = sfd_pkg::S_OUT;
      sfd_pkg::S_OUT:   if (!out_full) state_d = sfd_pkg::S_FB;
      sfd_pkg::S_FB:    state_d = sfd_pkg::S_STORE;
      sfd_pkg::S_STORE: state_d = sfd_pkg::S_IDLE;
      default:          state_d = sfd_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    ctrl = '0;
    unique case (state_q)
      sfd_pkg::S_IDLE:  ctrl.accept   = accept;
      sfd_pkg::S_WET:   ctrl.wet_mul  = 1'b1;
      sfd_pkg::S_OUT:   ctrl.out_load = !out_full;  // hold until the old beat leaves
      sfd_pkg::S_FB:    ctrl.fb_mul   = 1'b1;
      sfd_pkg::S_STORE: ctrl.store    = 1'b1;
      default:          ctrl = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sfd_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // write position and fill tracking
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q      <= '0;
      wrapped_q <= 1'b0;
    end else if (ctrl.store) begin
      if (wp_q == AddrBits'(HISTORY_DEPTH - 1)) begin
        wp_q      <= '0;
        wrapped_q <= 1'b1;
      end else begin
        wp_q <= wp_q + 1'b1;
      end
    end
  end

  // output beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

  sfd_channel #(
    .HISTORY_DEPTH (HISTORY_DEPTH),
    .SAMPLE_BITS   (SAMPLE_BITS)
  ) u_left (
    .clk_i      (clk_i),
    .ctrl_i     (ctrl),
    .wp_i       (wp_q),
    .wrapped_i  (wrapped_q),
    .dmod_i     (left_dmod),
    .wet_gain_i (wet_gain_q),
    .fb_gain_i  (fb_gain_q),
    .sample_i   (left_in_i),
    .out_o      (left_out_o)
  );

  sfd_channel #(
    .HISTORY_DEPTH (HISTORY_DEPTH),
    .SAMPLE_BITS   (SAMPLE_BITS)
  ) u_right (
    .clk_i      (clk_i),
    .ctrl_i     (ctrl),
    .wp_i       (wp_q),
    .wrapped_i  (wrapped_q),
    .dmod_i     (right_dmod),
    .wet_gain_i (wet_gain_q),
    .fb_gain_i  (fb_gain_q),
    .sample_i   (right_in_i),
    .out_o      (right_out_o)
  );

`ifndef SYNTH
  a_accept_to_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##2 (state_q == sfd_pkg::S_OUT))
    else $error("accepted frame did not reach the result step");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.out_load |-> !(out_valid_q && out_stall_i))
    else $error("result register loaded while a stalled beat is pending");

  a_wp_moves_on_store: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(wp_q) |-> ($past(state_q) == sfd_pkg::S_STORE))
    else $error("write position moved outside the store step");

  a_wrapped_sticks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wrapped_q |=> wrapped_q)
    else $error("fill flag dropped after the history wrapped");
`endif

endmodule
